>>> rtl/til_pkg.sv
// ----------------------------------------------------------------------------
// til_pkg
// Shared types and constants for the row-major index linearizer.
// ----------------------------------------------------------------------------
package til_pkg;

    localparam int NUM_DIMS     = 4;
    localparam int IDX_W        = 12;
    localparam int EXT_W        = 13;
    localparam int OFF_W        = 48;
    localparam int REG_IDX_W    = 2;
    localparam int BITS_PER_STG = 4;
    localparam int STG_PER_DIV  = OFF_W / BITS_PER_STG;
    localparam int NUM_STG      = NUM_DIMS * STG_PER_DIV;

    localparam logic OP_FLATTEN   = 1'b0;
    localparam logic OP_UNFLATTEN = 1'b1;

    localparam logic [EXT_W-1:0] EXT_RESET = EXT_W'(1);

    typedef struct packed {
        logic                             vld;
        logic                             op;
        logic [OFF_W-1:0]                 x;
        logic [EXT_W-1:0]                 r;
        logic [NUM_DIMS-1:0][IDX_W-1:0]   c;
    } t_stage;

endpackage

>>> rtl/tensor_index_linearizer.sv
// ----------------------------------------------------------------------------
// tensor_index_linearizer
// Four-dimensional row-major address unit: flatten indices to an offset or
// split an offset back into indices, using extents held in registers.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item transfers on a clock edge with start high and
//   busy low. busy never rises, so one item can enter every cycle.
//   Opcode flatten takes the index ports, opcode unflatten takes the offset.
//   Result channel: o_done marks one cycle with the result on the output
//   ports; the receiver must take it in that cycle.
//   Throughput is one item per cycle. The pipeline depth is set by the
//   unflatten path: four chained divisions of the 48-bit offset by the
//   extents, four quotient bits per stage. Flatten rides the same stages,
//   with one multiply-add for each dimension after the first.
//   Extent registers are written through i_wr_en, i_wr_idx, i_wr_data; the
//   user must do so only while no item is in flight, which the block does
//   not enforce. An extent of zero acts as one. Reset clears all stage valid
//   bits and sets every extent to one; items in flight are dropped.
// ----------------------------------------------------------------------------
module tensor_index_linearizer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_opcode,
    input  logic [til_pkg::IDX_W-1:0]   i_index_0,
    input  logic [til_pkg::IDX_W-1:0]   i_index_1,
    input  logic [til_pkg::IDX_W-1:0]   i_index_2,
    input  logic [til_pkg::IDX_W-1:0]   i_index_3,
    input  logic [til_pkg::OFF_W-1:0]   i_offset_in,
    input  logic                        i_wr_en,
    input  logic [til_pkg::REG_IDX_W-1:0] i_wr_idx,
    input  logic [til_pkg::EXT_W-1:0]   i_wr_data,
    output logic                        o_done,
    output logic [til_pkg::OFF_W-1:0]   o_offset_out,
    output logic [til_pkg::IDX_W-1:0]   o_coord_0,
    output logic [til_pkg::IDX_W-1:0]   o_coord_1,
    output logic [til_pkg::IDX_W-1:0]   o_coord_2,
    output logic [til_pkg::IDX_W-1:0]   o_coord_3
);

    localparam int NS = til_pkg::NUM_STG;
    localparam int ND = til_pkg::NUM_DIMS;

    logic [til_pkg::EXT_W-1:0] r_ext [ND];
    logic [til_pkg::EXT_W-1:0] w_ext [ND];
    til_pkg::t_stage           w_in  [NS];
    til_pkg::t_stage           n_stg [NS];
    til_pkg::t_stage           r_stg [NS];
    til_pkg::t_stage           w_last;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < ND; d++) begin
                r_ext[d] <= til_pkg::EXT_RESET;
            end
        end else if (i_wr_en) begin
            r_ext[i_wr_idx] <= i_wr_data;
        end
    end

    always_comb begin
        for (int d = 0; d < ND; d++) begin
            w_ext[d] = (r_ext[d] == '0) ? til_pkg::EXT_RESET : r_ext[d];
        end
    end

    always_comb begin
        w_in[0].vld  = start && !busy;
        w_in[0].op   = i_opcode;
        w_in[0].r    = '0;
        w_in[0].c    = '0;
        if (i_opcode == til_pkg::OP_UNFLATTEN) begin
            w_in[0].x = i_offset_in;
        end else begin
            w_in[0].x    = til_pkg::OFF_W'(i_index_0);
            w_in[0].c[1] = i_index_1;
            w_in[0].c[2] = i_index_2;
            w_in[0].c[3] = i_index_3;
        end
    end

    for (genvar s = 1; s < NS; s++) begin : g_link
        assign w_in[s] = r_stg[s-1];
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        localparam int P  = s / til_pkg::STG_PER_DIV;
        localparam int J  = s % til_pkg::STG_PER_DIV;
        localparam int DD = ND - 1 - P;

        always_comb begin
            til_pkg::t_stage            v;
            logic [til_pkg::EXT_W:0]    t;
            logic [til_pkg::OFF_W-1:0]  prod;
            v    = w_in[s];
            t    = '0;
            prod = '0;
            if (v.op == til_pkg::OP_UNFLATTEN) begin
                for (int b = 0; b < til_pkg::BITS_PER_STG; b++) begin
                    t   = {v.r, v.x[til_pkg::OFF_W-1]};
                    v.x = {v.x[til_pkg::OFF_W-2:0], 1'b0};
                    if (t >= {1'b0, w_ext[DD]}) begin
                        v.r    = til_pkg::EXT_W'(t - {1'b0, w_ext[DD]});
                        v.x[0] = 1'b1;
                    end else begin
                        v.r = t[til_pkg::EXT_W-1:0];
                    end
                end
                if (J == til_pkg::STG_PER_DIV - 1) begin
                    v.c[DD] = v.r[til_pkg::IDX_W-1:0];
                    v.r     = '0;
                end
            end else if (J == 0 && P != 0) begin
                prod = v.x * til_pkg::OFF_W'(w_ext[P]);
                v.x  = prod + til_pkg::OFF_W'(v.c[P]);
            end
            n_stg[s] = v;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg[s].vld <= 1'b0;
            end else begin
                r_stg[s] <= n_stg[s];
            end
        end
    end

    assign w_last = r_stg[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= w_last.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last.op == til_pkg::OP_UNFLATTEN) begin
            o_offset_out <= '0;
            o_coord_0    <= w_last.c[0];
            o_coord_1    <= w_last.c[1];
            o_coord_2    <= w_last.c[2];
            o_coord_3    <= w_last.c[3];
        end else begin
            o_offset_out <= w_last.x;
            o_coord_0    <= '0;
            o_coord_1    <= '0;
            o_coord_2    <= '0;
            o_coord_3    <= '0;
        end
    end

endmodule

>>> rtl/til_checker.sv
// ----------------------------------------------------------------------------
// til_checker
// Port-level checks for the row-major index linearizer.
// ----------------------------------------------------------------------------
module til_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        busy,
    input logic                        o_done,
    input logic [til_pkg::OFF_W-1:0]   o_offset_out,
    input logic [til_pkg::IDX_W-1:0]   o_coord_0,
    input logic [til_pkg::IDX_W-1:0]   o_coord_1,
    input logic [til_pkg::IDX_W-1:0]   o_coord_2,
    input logic [til_pkg::IDX_W-1:0]   o_coord_3
);

    a_no_done_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_flatten_zero_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_offset_out != '0) |->
        (o_coord_0 == '0 && o_coord_1 == '0 && o_coord_2 == '0 && o_coord_3 == '0))
        else $error("flatten result carries coordinates");

    a_unflatten_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_coord_0 != '0 || o_coord_1 != '0 || o_coord_2 != '0 ||
        o_coord_3 != '0)) |-> o_offset_out == '0)
        else $error("unflatten result carries an offset");

endmodule

bind tensor_index_linearizer til_checker u_til_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .busy         (busy),
    .o_done       (o_done),
    .o_offset_out (o_offset_out),
    .o_coord_0    (o_coord_0),
    .o_coord_1    (o_coord_1),
    .o_coord_2    (o_coord_2),
    .o_coord_3    (o_coord_3)
);
